/* src/cdt_pkg.sv */
// Shared constants for the countdown timer with alarm.
`timescale 1ns / 1ps
`default_nettype none
package cdt_pkg;

  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_PAUSE = 2'd2;
  localparam logic [1:0] MODE_ALARM = 2'd3;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic FIELD_MIN = 1'b0;

  localparam logic [2:0] KEY_OTHER  = 3'd0;
  localparam logic [2:0] KEY_DIGIT  = 3'd1;
  localparam logic [2:0] KEY_SWITCH = 3'd2;
  localparam logic [2:0] KEY_UP     = 3'd3;
  localparam logic [2:0] KEY_DOWN   = 3'd4;
  localparam logic [2:0] KEY_START  = 3'd5;
  localparam logic [2:0] KEY_RESET  = 3'd6;

  localparam logic       CFG_FLASH_PERIOD = 1'b0;
  localparam logic       CFG_RING_PERIOD  = 1'b1;

  localparam logic [15:0] FLASH_PERIOD_RST = 16'd400;
  localparam logic [15:0] RING_PERIOD_RST  = 16'd900;

  localparam logic [3:0]  DIGIT_MAX   = 4'd9;
  localparam logic [6:0]  MINUTES_MAX = 7'd99;
  localparam logic [5:0]  SECONDS_MAX = 6'd59;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  localparam logic [9:0]  MS_ROUND_UP = 10'd999;

  // ceil(x / 1000) = ((x + 999) * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^24
  localparam logic [23:0] RECIP_1000  = 24'd8589935;
  localparam int          RECIP_SHIFT = 33;

endpackage
`default_nettype wire

/* src/countdown_timer_with_alarm_core.sv */
// Countdown timer with alarm: key and tick requests in, one status result out per request.
//
// Usage:
//   Requests (op, key_class, digit_value, key_is_repeat, now_ms, audio_idle) enter on a
//   valid/ready channel; each one yields exactly one result (mode, set duration, field,
//   remaining and total ms, flash phase, beep and stop requests, acted) on a valid/ready
//   output channel.
//   A request is taken into an input register, evaluated in one pass against the timer
//   state, and its result is then registered in the output register, where out_valid
//   rises; throughput is one request per cycle while the receiver keeps taking results.
//   The longest path is the elapsed-time subtract, saturate and the reciprocal multiply
//   that rounds the remaining time up to whole seconds.
//   Configuration (flash and ring periods) is written through cfg_we/cfg_index/cfg_data by
//   the user only while the block is idle; the block does not enforce this. Both periods
//   return to 400 ms and 900 ms at reset. rst is synchronous: it empties both stages and
//   returns the timer to set mode with zero duration.
//   When the receiver stalls, the result holds in the output register, the input
//   register holds the next request, and in_ready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none
module countdown_timer_with_alarm_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         op,
  input  wire  [2:0]  key_class,
  input  wire  [3:0]  digit_value,
  input  wire         key_is_repeat,
  input  wire  [31:0] now_ms,
  input  wire         audio_idle,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  mode,
  output logic [6:0]  minutes_set,
  output logic [5:0]  seconds_set,
  output logic        selected_field,
  output logic [22:0] remaining_ms,
  output logic [22:0] run_total_ms,
  output logic        flash_state,
  output logic        beep_request,
  output logic        audio_stop,
  output logic        acted
);

  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  q;
    p = 15'(x) * 15'd205;
    q = p[14:11];
    return 4'(x - 7'({3'd0, q} * 7'd10));
  endfunction

  logic        flash_period_zero_unused;
  logic [15:0] flash_period;
  logic [15:0] ring_period;

  logic        req_valid;
  logic        req_op;
  logic [2:0]  req_class;
  logic [3:0]  req_digit;
  logic        req_repeat;
  logic [31:0] req_now;
  logic        req_idle;

  logic [1:0]  mode_state, mode_state_next;
  logic [6:0]  minutes, minutes_next;
  logic [5:0]  seconds, seconds_next;
  logic        field, field_next;
  logic [22:0] remain, remain_next;
  logic [12:0] remain_sec, remain_sec_next;
  logic [22:0] seg_remain, seg_remain_next;
  logic [22:0] total, total_next;
  logic [31:0] seg_time, seg_time_next;
  logic        flash, flash_next;
  logic [31:0] flash_time, flash_time_next;
  logic [31:0] beep_time, beep_time_next;
  logic        beep_v, stop_v, acted_v;

  logic        advance;
  logic [3:0]  dig_sat;
  logic [6:0]  sec_typed;
  logic [31:0] elapsed;
  logic [22:0] left;
  logic [23:0] left_sum;
  logic [47:0] left_prod;
  logic [12:0] left_sec;
  logic [12:0] set_sec;
  logic [22:0] dur;

  assign flash_period_zero_unused = 1'b0;
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_period <= cdt_pkg::FLASH_PERIOD_RST;
      ring_period  <= cdt_pkg::RING_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == cdt_pkg::CFG_FLASH_PERIOD) begin
        flash_period <= cfg_data;
      end else begin
        ring_period <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op     <= op;
      req_class  <= key_class;
      req_digit  <= digit_value;
      req_repeat <= key_is_repeat;
      req_now    <= now_ms;
      req_idle   <= audio_idle;
    end
  end

  // time left in the current run segment, and that time rounded up to seconds
  always_comb begin
    elapsed = req_now - seg_time;
    if (elapsed >= {9'd0, seg_remain}) begin
      left = '0;
    end else begin
      left = seg_remain - elapsed[22:0];
    end
    left_sum  = {1'b0, left} + {14'd0, cdt_pkg::MS_ROUND_UP};
    left_prod = 48'(left_sum) * 48'(cdt_pkg::RECIP_1000);
    left_sec  = left_prod[cdt_pkg::RECIP_SHIFT +: 13];
  end

  always_comb begin
    dig_sat   = (req_digit > cdt_pkg::DIGIT_MAX) ? cdt_pkg::DIGIT_MAX : req_digit;
    sec_typed = 7'({3'd0, mod10({1'b0, seconds})} * 7'd10) + {3'd0, dig_sat};
    set_sec   = 13'({6'd0, minutes} * 13'd60) + {7'd0, seconds};
    dur       = 23'({10'd0, set_sec} * {13'd0, cdt_pkg::MS_PER_SEC});
  end

  always_comb begin
    mode_state_next = mode_state;
    minutes_next    = minutes;
    seconds_next    = seconds;
    field_next      = field;
    remain_next     = remain;
    remain_sec_next = remain_sec;
    seg_remain_next = seg_remain;
    total_next      = total;
    seg_time_next   = seg_time;
    flash_next      = flash;
    flash_time_next = flash_time;
    beep_time_next  = beep_time;
    beep_v          = 1'b0;
    stop_v          = 1'b0;
    acted_v         = 1'b0;
    if (req_op == cdt_pkg::OP_KEY) begin
      if (mode_state == cdt_pkg::MODE_ALARM) begin
        stop_v          = !req_idle;
        mode_state_next = cdt_pkg::MODE_SET;
        acted_v         = 1'b1;
      end else if (req_repeat &&
                   !(req_class inside {cdt_pkg::KEY_UP, cdt_pkg::KEY_DOWN})) begin
        acted_v = 1'b0;
      end else begin
        case (req_class)
          cdt_pkg::KEY_DIGIT: begin
            if (mode_state == cdt_pkg::MODE_SET) begin
              if (field == cdt_pkg::FIELD_MIN) begin
                minutes_next = 7'({3'd0, mod10(minutes)} * 7'd10) + {3'd0, dig_sat};
              end else if (sec_typed > {1'b0, cdt_pkg::SECONDS_MAX}) begin
                seconds_next = cdt_pkg::SECONDS_MAX;
              end else begin
                seconds_next = sec_typed[5:0];
              end
              acted_v = 1'b1;
            end
          end
          cdt_pkg::KEY_SWITCH: begin
            if (mode_state == cdt_pkg::MODE_SET) begin
              field_next = !field;
              acted_v    = 1'b1;
            end
          end
          cdt_pkg::KEY_UP, cdt_pkg::KEY_DOWN: begin
            if (mode_state == cdt_pkg::MODE_SET) begin
              if (field == cdt_pkg::FIELD_MIN) begin
                if (req_class == cdt_pkg::KEY_UP) begin
                  minutes_next = (minutes == cdt_pkg::MINUTES_MAX) ? '0 : minutes + 7'd1;
                end else begin
                  minutes_next = (minutes == '0) ? cdt_pkg::MINUTES_MAX : minutes - 7'd1;
                end
              end else begin
                if (req_class == cdt_pkg::KEY_UP) begin
                  seconds_next = (seconds == cdt_pkg::SECONDS_MAX) ? '0 : seconds + 6'd1;
                end else begin
                  seconds_next = (seconds == '0) ? cdt_pkg::SECONDS_MAX : seconds - 6'd1;
                end
              end
              acted_v = 1'b1;
            end
          end
          cdt_pkg::KEY_START: begin
            acted_v = 1'b1;
            if (mode_state == cdt_pkg::MODE_RUN) begin
              remain_next     = left;
              remain_sec_next = left_sec;
              mode_state_next = cdt_pkg::MODE_PAUSE;
            end else if (mode_state == cdt_pkg::MODE_SET) begin
              if (dur != '0) begin
                seg_remain_next = dur;
                total_next      = dur;
                remain_next     = dur;
                remain_sec_next = set_sec;
                seg_time_next   = req_now;
                mode_state_next = cdt_pkg::MODE_RUN;
              end
            end else if (mode_state == cdt_pkg::MODE_PAUSE) begin
              seg_remain_next = remain;
              seg_time_next   = req_now;
              mode_state_next = cdt_pkg::MODE_RUN;
            end
          end
          cdt_pkg::KEY_RESET: begin
            stop_v = !req_idle;
            if (mode_state == cdt_pkg::MODE_SET) begin
              minutes_next = '0;
              seconds_next = '0;
            end
            mode_state_next = cdt_pkg::MODE_SET;
            acted_v         = 1'b1;
          end
          default: begin
            acted_v = flash_period_zero_unused;
          end
        endcase
      end
    end else begin
      if (mode_state == cdt_pkg::MODE_RUN) begin
        if (left == '0) begin
          remain_next     = '0;
          remain_sec_next = '0;
          mode_state_next = cdt_pkg::MODE_ALARM;
          flash_next      = 1'b1;
          flash_time_next = req_now;
          beep_v          = req_idle;
          beep_time_next  = req_now;
          acted_v         = 1'b1;
        end else begin
          acted_v         = (left_sec != remain_sec);
          remain_next     = left;
          remain_sec_next = left_sec;
        end
      end else if (mode_state == cdt_pkg::MODE_ALARM) begin
        if ((req_now - flash_time) >= {16'd0, flash_period}) begin
          flash_time_next = req_now;
          flash_next      = !flash;
          acted_v         = 1'b1;
        end
        if (((req_now - beep_time) >= {16'd0, ring_period}) && req_idle) begin
          beep_v         = 1'b1;
          beep_time_next = req_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state <= cdt_pkg::MODE_SET;
      minutes    <= '0;
      seconds    <= '0;
      field      <= cdt_pkg::FIELD_MIN;
      remain     <= '0;
      remain_sec <= '0;
      seg_remain <= '0;
      total      <= '0;
      seg_time   <= '0;
      flash      <= 1'b0;
      flash_time <= '0;
      beep_time  <= '0;
    end else if (advance) begin
      mode_state <= mode_state_next;
      minutes    <= minutes_next;
      seconds    <= seconds_next;
      field      <= field_next;
      remain     <= remain_next;
      remain_sec <= remain_sec_next;
      seg_remain <= seg_remain_next;
      total      <= total_next;
      seg_time   <= seg_time_next;
      flash      <= flash_next;
      flash_time <= flash_time_next;
      beep_time  <= beep_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode           <= mode_state_next;
      minutes_set    <= minutes_next;
      seconds_set    <= seconds_next;
      selected_field <= field_next;
      remaining_ms   <= remain_next;
      run_total_ms   <= total_next;
      flash_state    <= flash_next;
      beep_request   <= beep_v;
      audio_stop     <= stop_v;
      acted          <= acted_v;
    end
  end

endmodule
`default_nettype wire

/* src/cdt_checker.sv */
// Port-level checks for the countdown timer core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cdt_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  mode,
  input wire [6:0]  minutes_set,
  input wire [5:0]  seconds_set,
  input wire [22:0] remaining_ms,
  input wire [22:0] run_total_ms,
  input wire        beep_request,
  input wire        audio_stop
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(remaining_ms))
    else $error("stalled result changed");

  a_remain_le_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> remaining_ms <= run_total_ms)
    else $error("remaining time exceeds run total");

  a_beep_in_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep_request |-> mode == cdt_pkg::MODE_ALARM)
    else $error("beep requested outside alarm");

  a_stop_to_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && audio_stop |-> mode == cdt_pkg::MODE_SET)
    else $error("audio stop without return to set mode");

  a_set_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> minutes_set <= cdt_pkg::MINUTES_MAX && seconds_set <= cdt_pkg::SECONDS_MAX)
    else $error("set duration out of range");

endmodule

bind countdown_timer_with_alarm_core cdt_checker u_cdt_checker (.*);
`default_nettype wire
